// File: rtl/causal_depthwise_conv1d_assert.svh
`ifndef CAUSAL_DEPTHWISE_CONV1D_ASSERT_SVH
`define CAUSAL_DEPTHWISE_CONV1D_ASSERT_SVH
// concurrent check of an implication, held off during reset
`define CDC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// concurrent check that is active during reset too
`define CDC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: rtl/cdc_pkg.sv
package cdc_pkg;
   localparam int MAX_TAPS     = 16;
   localparam int MAX_CHANNELS = 64;
   localparam int SAMPLE_BITS  = 16;

   localparam int CMD_BITS = 2;
   localparam int CH_BITS  = 6;
   localparam int TAP_BITS = 4;
   localparam int IDX_BITS = 16;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [1:0] {
      CMD_COEF   = 2'd0,
      CMD_BIAS   = 2'd1,
      CMD_SAMPLE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_STRIDE  = 2'd0,
      REG_PADDING = 2'd1,
      REG_SEQLEN  = 2'd2,
      REG_TAPS    = 2'd3
   } reg_index_type;

   localparam logic SAME  = 1'b0;
   localparam logic VALID = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SHIFT,
      ST_MAC,
      ST_FINISH,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [1:0]                   cmd;
      logic [5:0]                   channel;
      logic [3:0]                   tap;
      logic signed [15:0]           coefficient;
      logic signed [31:0]           bias_value;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                         first;
   } req_type;

   typedef struct packed {
      logic [5:0]         out_channel;
      logic [15:0]        out_index;
      logic signed [31:0] value;
      logic               saturated;
   } rsp_type;
endpackage

// File: rtl/causal_depthwise_conv1d.sv
// Causal depthwise 1-D convolution, one channel per word, samples interleaved.
// Coefficient and bias loads are written in the fetch state. A sample passes the
// fetch state, then shift and MAC in turn over all MAX_TAPS taps, whether or not
// it yields a result: the history row of the channel lives in one memory with one
// read and one write port, so each of the MAX_TAPS entries is read in one cycle
// and shifted back in the next while the single multiplier accumulates the taps
// in use. The finish state waits for the last product when all MAX_TAPS taps are
// in use and while a result waits. After reset a clearing pass zeroes the history
// memory before the first word is taken; CSR writes are accepted throughout, and
// each one holds off input words while the output length is recomputed. Results
// sit in an output register so the next word may enter while a result waits.
module causal_depthwise_conv1d
   import cdc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_ADDR_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);
   localparam int TB = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int HD = MAX_CHANNELS * MAX_TAPS;
   localparam int HB = (HD > 1) ? $clog2(HD) : 1;
   localparam int TCB = $clog2(MAX_TAPS + 1);

   // configuration
   logic [7:0]  stride_ff;
   logic        pad_ff;
   logic [15:0] seqlen_ff;
   logic [4:0]  taps_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= 8'd1;
         pad_ff    <= SAME;
         seqlen_ff <= 16'd1024;
         taps_ff   <= 5'd16;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_STRIDE:  stride_ff <= csr_wdata[7:0];
            REG_PADDING: pad_ff    <= csr_wdata[0];
            REG_SEQLEN:  seqlen_ff <= csr_wdata;
            REG_TAPS:    taps_ff   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   logic [7:0]     eff_stride;
   logic [TCB-1:0] eff_taps;
   assign eff_stride = (stride_ff == 8'd0) ? 8'd1 : stride_ff;
   always_comb begin
      if (taps_ff == 5'd0) eff_taps = TCB'(1);
      else if (32'(taps_ff) > MAX_TAPS) eff_taps = TCB'(MAX_TAPS);
      else eff_taps = TCB'(taps_ff);
   end

   // output length: iterative divider over 17 quotient bits, run after reset and on each CSR write
   logic [16:0] len_ff, len_in;
   logic [16:0] num;
   logic        len_busy_ff;
   logic [4:0]  div_cnt_ff;
   logic [16:0] quo_ff, rem_ff;
   logic        cfg_dirty_ff;
   always_comb begin
      if (pad_ff == VALID) num = {1'b0, seqlen_ff} - 17'(eff_taps);
      else num = {1'b0, seqlen_ff} + 17'(eff_stride) - 17'd1;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_dirty_ff <= 1'b1;
         len_busy_ff  <= 1'b0;
         div_cnt_ff   <= '0;
         len_ff       <= 17'd1024;
      end else if (csr_valid) begin
         cfg_dirty_ff <= 1'b1;
         len_busy_ff  <= 1'b0;
      end else if (cfg_dirty_ff) begin
         cfg_dirty_ff <= 1'b0;
         len_busy_ff  <= 1'b1;
         div_cnt_ff   <= 5'd17;
         quo_ff       <= num;
         rem_ff       <= '0;
      end else if (len_busy_ff) begin
         if (div_cnt_ff == 5'd0) begin
            len_busy_ff <= 1'b0;
            len_ff      <= len_in;
         end else begin
            div_cnt_ff <= div_cnt_ff - 5'd1;
            if ({rem_ff[15:0], quo_ff[16]} >= 17'(eff_stride)) begin
               rem_ff <= {rem_ff[15:0], quo_ff[16]} - 17'(eff_stride);
               quo_ff <= {quo_ff[15:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[15:0], quo_ff[16]};
               quo_ff <= {quo_ff[15:0], 1'b0};
            end
         end
      end
   end
   always_comb begin
      if (pad_ff == VALID) begin
         if (seqlen_ff < 16'(eff_taps)) len_in = '0;
         else len_in = quo_ff + 17'd1;
      end else len_in = quo_ff;
   end

   // memories
   logic signed [SAMPLE_BITS-1:0] hist_mem [HD];
   logic signed [15:0]            coef_mem [HD];
   logic signed [31:0]            bias_mem [MAX_CHANNELS];
   logic [15:0]                   pos_mem  [MAX_CHANNELS];
   logic [7:0]                    ph_mem   [MAX_CHANNELS];
   logic [15:0]                   nxt_mem  [MAX_CHANNELS];

   logic                          h_we;
   logic [HB-1:0]                 h_wa, h_ra;
   logic signed [SAMPLE_BITS-1:0] h_wd, h_rd_ff;
   logic signed [15:0]            c_rd_ff;
   logic signed [31:0]            b_rd_ff;
   logic [15:0]                   pos_rd_ff, nxt_rd_ff;
   logic [7:0]                    ph_rd_ff;

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CB-1:0] ch;
   logic [TB-1:0] k_ff, k_in;
   logic [HB-1:0] clr_ff;
   logic          ch_ok, tap_ok;
   logic signed [SAMPLE_BITS-1:0] carry_ff, carry_in;
   logic signed [47:0]            acc_ff;
   logic signed [31:0]            prod_ff;
   logic                          prod_v_ff;
   logic          emit_ff;
   logic [15:0]   pos_v, nxt_v;
   logic [7:0]    ph_v;
   logic          meta_we;
   logic [15:0]   pos_w, nxt_w;
   logic [7:0]    ph_w;
   logic          rsp_load;
   logic          clr_meta;
   logic [15:0]   nxt_v_ff;

   assign ch     = CB'(req_ff.channel);
   assign ch_ok  = 32'(req_ff.channel) < MAX_CHANNELS;
   assign tap_ok = 32'(req_ff.tap) < MAX_TAPS;

   always_ff @(posedge clock) begin
      if (h_we) hist_mem[h_wa] <= h_wd;
      h_rd_ff <= hist_mem[h_ra];
      c_rd_ff <= coef_mem[HB'(32'(ch) * MAX_TAPS + 32'(k_in))];
      b_rd_ff <= bias_mem[ch];
      pos_rd_ff <= pos_mem[ch];
      ph_rd_ff  <= ph_mem[ch];
      nxt_rd_ff <= nxt_mem[ch];
      if (state_ff == ST_FETCH && ch_ok && req_ff.cmd == CMD_COEF && tap_ok)
         coef_mem[HB'(32'(ch) * MAX_TAPS + 32'(req_ff.tap))] <= req_ff.coefficient;
      if (state_ff == ST_FETCH && ch_ok && req_ff.cmd == CMD_BIAS)
         bias_mem[ch] <= req_ff.bias_value;
      if (meta_we) begin
         pos_mem[ch] <= pos_w;
         ph_mem[ch]  <= ph_w;
         nxt_mem[ch] <= nxt_w;
      end else if (clr_meta && 32'(clr_ff) < MAX_CHANNELS) begin
         // clearing pass zeroes channel metadata too
         pos_mem[CB'(clr_ff)] <= '0;
         ph_mem[CB'(clr_ff)]  <= '0;
         nxt_mem[CB'(clr_ff)] <= '0;
      end
   end

   // metadata with first applied; position/phase/next_output reset at power-up
   // is covered by the clearing pass
   assign pos_v = req_ff.first ? 16'd0 : pos_rd_ff;
   assign ph_v  = req_ff.first ? 8'd0  : ph_rd_ff;
   assign nxt_v = req_ff.first ? 16'd0 : nxt_rd_ff;

   logic emit_now;
   assign emit_now = (ph_v == 8'd0) && ({1'b0, nxt_v} < len_ff);

   assign req_ready = (state_ff == ST_IDLE) && !cfg_dirty_ff && !len_busy_ff;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      carry_in = carry_ff;
      h_we     = 1'b0;
      h_wa     = HB'(32'(ch) * MAX_TAPS + 32'(k_ff));
      h_ra     = h_wa;
      h_wd     = carry_ff;
      meta_we  = 1'b0;
      clr_meta = 1'b0;
      pos_w    = (pos_v == 16'hFFFF) ? pos_v : pos_v + 16'd1;
      ph_w     = (9'(ph_v) + 9'd1 >= 9'(eff_stride)) ? 8'd0 : ph_v + 8'd1;
      nxt_w    = emit_now ? nxt_v + 16'd1 : nxt_v;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            h_we = 1'b1;
            h_wa = clr_ff;
            h_wd = '0;
            clr_meta = 1'b1;
            if (32'(clr_ff) == HD - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            k_in = '0;
            if (req_valid && req_ready) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            // channel metadata and tap 0 are being read this cycle
            if (ch_ok && req_ff.cmd == CMD_SAMPLE) begin
               carry_in = req_ff.sample;
               state_in = ST_SHIFT;
            end else state_in = ST_IDLE;
         end
         ST_SHIFT: begin
            // read data of tap k is valid; write newer sample into tap k
            h_we     = 1'b1;
            h_wd     = carry_ff;
            carry_in = req_ff.first ? '0 : h_rd_ff;
            state_in = ST_MAC;
            if (32'(k_ff) == MAX_TAPS - 1) begin
               meta_we  = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_MAC: begin
            k_in     = k_ff + TB'(1);
            state_in = ST_SHIFT;
            h_ra     = HB'(32'(ch) * MAX_TAPS + 32'(k_in));
         end
         ST_FINISH: begin
            if (!prod_v_ff && (!rsp_valid || rsp_ready)) begin
               rsp_load = emit_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // multiplier: the tap just written is the shifted-in sample carry_ff
   always_ff @(posedge clock) begin
      prod_v_ff <= (state_ff == ST_SHIFT) && (32'(k_ff) < 32'(eff_taps));
      prod_ff   <= 32'(c_rd_ff) * 32'(carry_ff);
      if (state_ff == ST_FETCH) acc_ff <= '0;
      else if (prod_v_ff) acc_ff <= acc_ff + 48'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + HB'(1);
         if (state_ff == ST_SHIFT && k_ff == '0) emit_ff <= emit_now;
      end
      k_ff     <= k_in;
      carry_ff <= carry_in;
      if (state_ff == ST_IDLE && req_valid && req_ready) req_ff <= req_data;
      if (state_ff == ST_SHIFT && k_ff == '0) nxt_v_ff <= nxt_v;
   end

   // rounding and saturation
   logic signed [48:0] rnd, tot;
   logic signed [31:0] val;
   logic               sat;
   always_comb begin
      rnd = (49'(acc_ff) + 49'sd16384) >>> 15;
      tot = rnd + 49'(b_rd_ff);
      sat = 1'b0;
      val = tot[31:0];
      if (tot > 49'sd2147483647) begin
         val = 32'sh7FFFFFFF;
         sat = 1'b1;
      end else if (tot < -49'sd2147483648) begin
         val = 32'sh80000000;
         sat = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (rsp_load) begin
         rsp_data.out_channel <= req_ff.channel;
         rsp_data.out_index   <= nxt_v_ff;
         rsp_data.value       <= val;
         rsp_data.saturated   <= sat;
      end
   end
endmodule

// File: rtl/cdc_checker.sv
`include "causal_depthwise_conv1d_assert.svh"
module cdc_checker
   import cdc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   `CDC_ASSERT(rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result word dropped or changed")
   `CDC_ASSERT_ALWAYS(rsp_reset, clock, reset |=> !rsp_valid, "result word during reset")
   `CDC_ASSERT(sat_edge, clock, reset, rsp_valid && rsp_data.saturated |-> rsp_data.value == 32'sh7FFFFFFF || rsp_data.value == 32'sh80000000, "saturated flag without clipped value")
   `CDC_ASSERT(one_per_word, clock, reset, req_valid && req_ready |=> !req_ready, "word accepted on consecutive cycles")
endmodule

bind causal_depthwise_conv1d cdc_checker u_cdc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
